>>> src/nui_pkg.sv
// Package for the next-use index block: widths, commands, status codes.
// Used by next_use_index and the testbench.
`default_nettype none
package nui_pkg;
  localparam int unsigned MaxAddrsDefault = 256;
  localparam int unsigned MaxUsesDefault  = 4096;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ADDR_FULL = 2'd1,
    ST_USE_FULL  = 2'd2
  } status_t;
endpackage
`default_nettype wire

>>> src/nui_in_if.sv
// Input channel of the next-use index block: valid/ready and one command word.
// No dependencies.
`default_nettype none
interface nui_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [63:0] addr;
  logic [31:0] inst_index;
  logic signed [32:0] pos;
  modport source (output valid, cmd, addr, inst_index, pos, input ready);
  modport sink   (input valid, cmd, addr, inst_index, pos, output ready);
endinterface
`default_nettype wire

>>> src/nui_out_if.sv
// Output channel of the next-use index block: valid/ready and one result word.
// No dependencies.
`default_nettype none
interface nui_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] next_use;
  logic [1:0]  status;
  modport source (output valid, found, next_use, status, input ready);
  modport sink   (input valid, found, next_use, status, output ready);
endinterface
`default_nettype wire

>>> src/nui_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module nui_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output      logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> src/next_use_index.sv
// Top level of the next-use index: address table, use lists and the sequencer.
// Depends on nui_pkg, nui_in_if, nui_out_if and nui_ram.
//
//  channel | dir | word
//  in      | in  | cmd, addr, inst_index, pos
//  out     | out | found, next_use, status
//
// Clear goes straight to the result; add and query first scan the address table
// one entry at a time (read, then compare). A query then walks its use list one
// node at a time (one read of the use store per node).
// The block is busy from acceptance until the result word is taken.
// Reset (rst, synchronous) empties the table at once; no clearing pass.
// A stalled output holds the result and keeps the input side not ready.
`default_nettype none
module next_use_index
  import nui_pkg::*;
#(
  parameter int unsigned MaxAddrs = MaxAddrsDefault,
  parameter int unsigned MaxUses  = MaxUsesDefault
) (
  input wire logic clk,
  input wire logic rst,
  nui_in_if.sink   in,
  nui_out_if.source out
);
  localparam int unsigned AW  = $clog2(MaxAddrs);
  localparam int unsigned UW  = $clog2(MaxUses);
  localparam int unsigned ACW = $clog2(MaxAddrs + 1);
  localparam int unsigned UCW = $clog2(MaxUses + 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SCAN  = 8'b0000_0010,
    S_CMP   = 8'b0000_0100,
    S_ENT   = 8'b0000_1000,
    S_WALK  = 8'b0001_0000,
    S_WCHK  = 8'b0010_0000,
    S_WLINK = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state;
  logic [1:0]  cmd;
  logic [63:0] addr;
  logic [31:0] inst_index;
  logic signed [33:0] pos;
  logic [ACW-1:0] scan;
  logic [ACW-1:0] entries_stored;
  logic [UCW-1:0] uses_stored;
  logic [AW-1:0]  ent;
  logic [UCW-1:0] cur;
  logic [UCW-1:0] tail;
  logic [MaxAddrs-1:0] entry_valid;

  // Address tag memory, entry record memory (head unused: tail and cursor).
  logic           tag_we;
  logic [AW-1:0]  tag_wa;
  logic [63:0]    tag_rd;
  logic           rec_we;
  logic [AW-1:0]  rec_wa;
  logic [2*UCW-1:0] rec_wd, rec_rd;
  logic           use_we;
  logic [UW-1:0]  use_wa, use_ra;
  logic [31:0]    use_val_rd;
  logic           lnk_we;
  logic [UW-1:0]  lnk_wa;
  logic [UCW-1:0] lnk_wd, lnk_rd;
  logic [AW-1:0]  tag_ra;

  nui_ram #(.Width(64), .Depth(MaxAddrs)) u_tag (
    .clk, .we(tag_we), .waddr(tag_wa), .wdata(addr), .raddr(tag_ra), .rdata(tag_rd));
  nui_ram #(.Width(2*UCW), .Depth(MaxAddrs)) u_rec (
    .clk, .we(rec_we), .waddr(rec_wa), .wdata(rec_wd), .raddr(tag_ra), .rdata(rec_rd));
  nui_ram #(.Width(32), .Depth(MaxUses)) u_val (
    .clk, .we(use_we), .waddr(use_wa), .wdata(inst_index), .raddr(use_ra),
    .rdata(use_val_rd));
  nui_ram #(.Width(UCW), .Depth(MaxUses)) u_lnk (
    .clk, .we(lnk_we), .waddr(lnk_wa), .wdata(lnk_wd), .raddr(use_ra), .rdata(lnk_rd));

  localparam logic [UCW-1:0] NoNode = UCW'(MaxUses);

  logic hit;
  assign hit = entry_valid[ent] && (tag_rd == addr);
  assign tag_ra = scan[AW-1:0];
  assign use_ra = cur[UW-1:0];
  assign in.ready = (state == S_IDLE);

  always_comb begin
    tag_we = 1'b0; rec_we = 1'b0; use_we = 1'b0; lnk_we = 1'b0;
    tag_wa = entries_stored[AW-1:0];
    rec_wa = ent;
    rec_wd = {tail, cur};
    use_wa = uses_stored[UW-1:0];
    lnk_wa = uses_stored[UW-1:0];
    lnk_wd = NoNode;
    if (state == S_ENT && cmd == CMD_ADD) begin
      if (!hit) begin
        if (entries_stored < ACW'(MaxAddrs) && uses_stored < UCW'(MaxUses)) begin
          use_we = 1'b1; lnk_we = 1'b1; tag_we = 1'b1; rec_we = 1'b1;
          rec_wa = entries_stored[AW-1:0];
          rec_wd = {uses_stored, uses_stored};
        end
      end else if (uses_stored < UCW'(MaxUses)) begin
        use_we = 1'b1; lnk_we = 1'b1; rec_we = 1'b1;
        rec_wd = {uses_stored, (rec_rd[UCW-1:0] >= NoNode) ? uses_stored : rec_rd[UCW-1:0]};
      end
    end else if (state == S_WLINK) begin
      // Second half of an append: link the old tail to the new node, or for a new entry rewrite the new node end.
      lnk_we = 1'b1;
      if (tail < NoNode) begin
        lnk_wa = tail[UW-1:0];
        lnk_wd = uses_stored - UCW'(1);
      end else begin
        lnk_wa = UW'(uses_stored - UCW'(1));
      end
    end else if (state == S_WCHK && cmd == CMD_QUERY) begin
      if (cur >= NoNode || $signed({2'b00, use_val_rd}) > pos) begin
        rec_we = 1'b1;
        rec_wd = {tail, cur};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out.valid <= 1'b0;
      entry_valid <= '0;
      entries_stored <= '0;
      uses_stored <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in.valid) begin
            cmd <= in.cmd;
            addr <= in.addr;
            inst_index <= in.inst_index;
            pos <= {in.pos[32], in.pos};
            scan <= '0;
            out.found <= 1'b0;
            out.next_use <= '1;
            out.status <= ST_OK;
            if (in.cmd == CMD_CLEAR) begin
              entry_valid <= '0;
              entries_stored <= '0;
              uses_stored <= '0;
              state <= S_DONE;
              out.valid <= 1'b1;
            end else if ((in.cmd == CMD_ADD || in.cmd == CMD_QUERY) && in.addr != '0) begin
              state <= S_SCAN;
            end else begin
              state <= S_DONE;
              out.valid <= 1'b1;
            end
          end
        end
        S_SCAN: begin
          // Read address issued; compare next cycle.
          ent <= scan[AW-1:0];
          state <= S_CMP;
        end
        S_CMP: begin
          if (hit || scan + ACW'(1) >= entries_stored || scan + ACW'(1) >= ACW'(MaxAddrs))
          begin
            state <= S_ENT;
            if (!hit) ent <= entries_stored[AW-1:0];
          end else begin
            scan <= scan + ACW'(1);
            state <= S_SCAN;
          end
        end
        S_ENT: begin
          if (cmd == CMD_ADD) begin
            if (!hit && entries_stored >= ACW'(MaxAddrs)) begin
              out.status <= ST_ADDR_FULL;
              state <= S_DONE; out.valid <= 1'b1;
            end else if (uses_stored >= UCW'(MaxUses)) begin
              out.status <= ST_USE_FULL;
              state <= S_DONE; out.valid <= 1'b1;
            end else begin
              uses_stored <= uses_stored + UCW'(1);
              if (!hit) begin
                entry_valid[entries_stored[AW-1:0]] <= 1'b1;
                entries_stored <= entries_stored + ACW'(1);
                tail <= NoNode;
              end else begin
                tail <= rec_rd[2*UCW-1:UCW];
              end
              state <= S_WLINK;
            end
          end else if (!hit) begin
            state <= S_DONE; out.valid <= 1'b1;
          end else begin
            cur <= rec_rd[UCW-1:0];
            tail <= rec_rd[2*UCW-1:UCW];
            state <= S_WALK;
          end
        end
        S_WLINK: begin
          state <= S_DONE; out.valid <= 1'b1;
        end
        S_WALK: state <= S_WCHK;
        S_WCHK: begin
          if (cur >= NoNode) begin
            state <= S_DONE; out.valid <= 1'b1;
          end else if ($signed({2'b00, use_val_rd}) > pos) begin
            out.found <= 1'b1;
            out.next_use <= use_val_rd;
            state <= S_DONE; out.valid <= 1'b1;
          end else begin
            cur <= lnk_rd;
            state <= S_WALK;
          end
        end
        S_DONE: begin
          if (out.ready) begin
            out.valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    out.valid |-> !in.ready) else $error("ready while result pending");
  a_uses_bound: assert property (@(posedge clk) disable iff (rst)
    uses_stored <= UCW'(MaxUses)) else $error("use count overflow");
  a_ent_bound: assert property (@(posedge clk) disable iff (rst)
    entries_stored <= ACW'(MaxAddrs)) else $error("entry count overflow");
  a_found_ones: assert property (@(posedge clk) disable iff (rst)
    (out.valid && !out.found) |-> out.next_use == '1) else $error("bad not-found word");
endmodule
`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the next-use index block: random and directed command words.
// Depends on nui_pkg, nui_in_if, nui_out_if and next_use_index.
`timescale 1ns / 100ps
module tb_top;
  import nui_pkg::*;

  localparam int unsigned NumAddrs = MaxAddrsDefault;
  localparam int unsigned NumUses  = MaxUsesDefault;
  localparam logic [1:0] CmdUnused = 2'd3;
  localparam int unsigned RandomWords = 1150;
  localparam longint unsigned CycleLimit = 4000000;

  typedef struct {
    logic [1:0]         cmd;
    logic [63:0]        addr;
    logic [31:0]        idx;
    logic signed [32:0] pos;
    bit                 wait_idle;
  } cmd_word_t;

  typedef struct {
    logic        found;
    logic [31:0] next_use;
    logic [1:0]  status;
  } result_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  nui_in_if  in ();
  nui_out_if out ();

  next_use_index DUT (.clk(clk), .rst(rst), .in(in), .out(out));

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Model of the index: address table and linked use lists.
  logic [63:0] tag_of [NumAddrs];
  bit          live   [NumAddrs];
  int unsigned tail_of [NumAddrs];
  int unsigned cursor_of [NumAddrs];
  logic [31:0] use_val [NumUses];
  int unsigned use_nxt [NumUses];
  int unsigned n_uses = 0;
  int unsigned n_entries = 0;

  cmd_word_t    pending_words[$];
  result_word_t expected_results[$];
  int unsigned  errors = 0;
  int unsigned  n_results = 0;
  bit           gen_done = 0;

  function automatic int unsigned lookup_entry(logic [63:0] a);
    for (int unsigned e = 0; e < NumAddrs; e++) begin
      if (live[e] && tag_of[e] == a) return e;
    end
    return NumAddrs;
  endfunction

  function automatic result_word_t predict_result(cmd_word_t w);
    result_word_t r;
    int unsigned e, n, c, steps;
    r.found = 1'b0;
    r.next_use = '1;
    r.status = ST_OK;
    case (w.cmd)
      CMD_CLEAR: begin
        for (int unsigned i = 0; i < NumAddrs; i++) live[i] = 0;
        n_uses = 0;
        n_entries = 0;
      end
      CMD_ADD: begin
        if (w.addr != 0) begin
          e = lookup_entry(w.addr);
          if (e >= NumAddrs && n_entries >= NumAddrs) r.status = ST_ADDR_FULL;
          else if (n_uses >= NumUses) r.status = ST_USE_FULL;
          else begin
            n = n_uses++;
            use_val[n] = w.idx;
            use_nxt[n] = NumUses;
            if (e >= NumAddrs) begin
              e = n_entries++;
              live[e] = 1;
              tag_of[e] = w.addr;
              tail_of[e] = n;
              cursor_of[e] = n;
            end else begin
              use_nxt[tail_of[e]] = n;
              tail_of[e] = n;
              if (cursor_of[e] >= NumUses) cursor_of[e] = n;
            end
          end
        end
      end
      CMD_QUERY: begin
        if (w.addr != 0) begin
          e = lookup_entry(w.addr);
          if (e < NumAddrs) begin
            c = cursor_of[e];
            steps = 0;
            while (steps < NumUses && c < NumUses) begin
              if (longint'({1'b0, use_val[c]}) > longint'(w.pos)) break;
              c = use_nxt[c];
              steps++;
            end
            cursor_of[e] = c;
            if (c < NumUses) begin
              r.found = 1'b1;
              r.next_use = use_val[c];
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic push_word(logic [1:0] cmd, logic [63:0] addr, logic [31:0] idx,
                           longint p, bit wait_idle = 0);
    cmd_word_t w;
    w.cmd = cmd;
    w.addr = addr;
    w.idx = idx;
    w.pos = p[32:0];
    w.wait_idle = wait_idle;
    pending_words.push_back(w);
  endtask

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch in %s at result %0d: got %0h, expected %0h",
             field, n_results, got, want);
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: offers queued words, predicts each one as it is accepted.
  cmd_word_t   cur_word;
  bit          offering = 0;
  int unsigned send_gap = 0;
  int unsigned settle = 0;
  bit          send_calm = 0;

  initial begin
    in.valid = 1'b0;
    in.cmd = CMD_CLEAR;
    in.addr = '0;
    in.inst_index = '0;
    in.pos = '0;
    out.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      in.valid <= 1'b0;
    end else begin
      if (in.valid && in.ready) begin
        expected_results.push_back(predict_result(cur_word));
        offering = 0;
      end
      if (expected_results.size() != 0) settle = 0;
      else if (settle < 16) settle++;
      if ($urandom_range(0, 199) == 0) send_calm = !send_calm;
      if (!offering) begin
        if (send_gap > 0) begin
          send_gap--;
          in.valid <= 1'b0;
        end else if (pending_words.size() != 0 &&
                     (!pending_words[0].wait_idle || settle >= 12)) begin
          cur_word = pending_words.pop_front();
          in.cmd <= cur_word.cmd;
          in.addr <= cur_word.addr;
          in.inst_index <= cur_word.idx;
          in.pos <= cur_word.pos;
          in.valid <= 1'b1;
          offering = 1;
          send_gap = send_calm ? 0 : pick_gap();
        end else begin
          in.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: takes result words with random stalls and checks them in order.
  result_word_t want;
  int unsigned  hold_left = 0;
  bit           long_hold_done = 0;
  bit           recv_calm = 0;

  always @(posedge clk) begin
    if (rst) begin
      out.ready <= 1'b0;
    end else begin
      if (out.valid && out.ready) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("unexpected result word at result %0d", n_results);
        end else begin
          want = expected_results.pop_front();
          if (out.found !== want.found)
            report("found", 64'(out.found), 64'(want.found));
          if (out.next_use !== want.next_use)
            report("next_use", 64'(out.next_use), 64'(want.next_use));
          if (out.status !== want.status)
            report("status", 64'(out.status), 64'(want.status));
        end
        n_results++;
      end
      if ($urandom_range(0, 249) == 0) recv_calm = !recv_calm;
      if (hold_left > 0) begin
        hold_left--;
        out.ready <= 1'b0;
      end else if (n_results >= 500 && !long_hold_done) begin
        // One long hold so the block backs up and stalls its input.
        long_hold_done = 1;
        hold_left = 3000;
        out.ready <= 1'b0;
      end else if (recv_calm) begin
        out.ready <= 1'b1;
      end else if ($urandom_range(0, 99) < 3) begin
        hold_left = $urandom_range(10, 40);
        out.ready <= 1'b0;
      end else begin
        out.ready <= ($urandom_range(0, 9) < 7);
      end
    end
  end

  longint unsigned cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("next_use_index test failed");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    logic [63:0] pool[$];
    logic [63:0] a;
    longint      cur_idx;
    int unsigned total, epoch_len, r;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, every command and the special cases.
    push_word(CMD_QUERY, 64'h1, 0, 5);
    push_word(CMD_ADD, 64'h0, 7, 0);
    push_word(CMD_QUERY, 64'h0, 0, -1);
    push_word(CMD_ADD, '1, 0, 0);
    push_word(CMD_ADD, '1, 32'hFFFF_FFFE, 0);
    push_word(CMD_ADD, 64'h8000_0000_0000_0001, 10, 0);
    push_word(CMD_QUERY, '1, 0, -1);
    push_word(CMD_QUERY, '1, 0, 0);
    push_word(CMD_QUERY, '1, 0, 64'h0FFFF_FFFF);
    push_word(CMD_QUERY, '1, 0, -1);
    push_word(CMD_ADD, '1, 32'hFFFF_FFFE, 0);
    push_word(CMD_QUERY, '1, 0, 32'hFFFF_FFFD);
    push_word(CMD_ADD, 64'h8000_0000_0000_0001, 4, 0);
    push_word(CMD_QUERY, 64'h8000_0000_0000_0001, 0, 9);
    push_word(CMD_QUERY, 64'h8000_0000_0000_0001, 0, 3);
    push_word(CMD_QUERY, 64'h5555_AAAA_5555_AAAA, 0, 3);
    push_word(CmdUnused, '1, '1, -1);
    push_word(CMD_CLEAR, '0, '0, 0);
    push_word(CMD_QUERY, '1, 0, -1);

    // Address table full: two more distinct addresses than entries.
    push_word(CMD_CLEAR, '0, '0, 0, 1);
    for (int unsigned i = 1; i <= NumAddrs + 2; i++)
      push_word(CMD_ADD, {$urandom, $urandom} | 64'h1 << 40 | i, i, 0);
    push_word(CMD_ADD, 64'h1 << 40 | 64'd3, 900, 0);
    push_word(CMD_QUERY, 64'h1 << 40 | 64'd3, 0, 3);
    push_word(CMD_CLEAR, '0, '0, 0, 1);

    // Random epochs: a pool of addresses, mostly ordered adds and queries.
    total = 0;
    while (total < RandomWords) begin
      push_word(CMD_CLEAR, '0, '0, 0, (total > 600 && total < 640));
      total++;
      pool.delete();
      repeat ($urandom_range(1, 24)) pool.push_back({$urandom, $urandom} | 64'h1);
      cur_idx = ($urandom_range(0, 3) == 0) ? longint'(32'hFFFF_F000) + $urandom_range(0, 2048)
                                           : longint'($urandom_range(0, 1000));
      epoch_len = $urandom_range(40, 150);
      repeat (epoch_len) begin
        r = $urandom_range(0, 99);
        a = pool[$urandom_range(0, pool.size() - 1)];
        if (r < 45) begin
          cur_idx += $urandom_range(0, 3);
          if (cur_idx > 64'hFFFF_FFFE) cur_idx = 64'hFFFF_FFFE;
          push_word(CMD_ADD, a, cur_idx[31:0], 0);
        end else if (r < 85) push_word(CMD_QUERY, a, 0, cur_idx - $urandom_range(0, 8));
        else if (r < 88) push_word(CMD_QUERY, a, 0, -1);
        else if (r < 90) push_word(CMD_QUERY, a, 0, 64'h0FFFF_FFFF);
        else if (r < 93) push_word(r[0] ? CMD_ADD : CMD_QUERY, '0, $urandom, cur_idx);
        else if (r < 95) push_word(CMD_QUERY, {$urandom, $urandom}, 0, cur_idx);
        else if (r < 97) push_word(CmdUnused, a, $urandom, cur_idx);
        else if (r < 99) push_word(CMD_ADD, a, $urandom, 0);
        else push_word(CMD_CLEAR, '0, '0, 0);
        total++;
      end
    end
    gen_done = 1;

    while (pending_words.size() != 0 || in.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("next_use_index test passed");
    end else begin
      $display("next_use_index test failed");
    end
    $finish;
  end
endmodule

>>> next_use_index.f
src/nui_pkg.sv
src/nui_in_if.sv
src/nui_out_if.sv
src/nui_ram.sv
src/next_use_index.sv
tb/tb_top.sv
